### src/radix_digit_converter_assert.svh
// assertion macros for the checker file
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// condition and consequence in the same cycle
`define RDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rdc_pkg.sv
`default_nettype none

package rdc_pkg;

  // field widths
  localparam int VALUE_W     = 31;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // digit stack depth default
  localparam int MAX_DIGITS_DEF = 32;

  // divider: one byte of the dividend per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = 4;
  localparam int DIV_W     = DIV_BITS * DIV_STEPS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  // character codes
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'd65;
  localparam logic [CHAR_W-1:0]  CHAR_Z     = 7'd90;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POP_REQ,
    ST_POP_LOAD
  } rdc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic pop_req;
    logic pop_load;
  } rdc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic quo_zero;
    logic level_zero;
    logic out_free;
  } rdc_sts_t;

  // digit value to ascii character
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    if (d < DEC_DIGITS) begin
      digit_to_char = CHAR_ZERO + CHAR_W'(d);
    end else begin
      digit_to_char = CHAR_A + CHAR_W'(d - DEC_DIGITS);
    end
  endfunction

endpackage

`default_nettype wire

### src/radix_digit_converter.sv
`default_nettype none

// Converts one 31-bit value into ASCII digits in a radix from 2 to 36 ('0'-'9'
// then 'A'-'Z'), most significant digit first, tlast on the final digit; a
// zero value gives one '0' and a radix outside 2..36 is clamped into it. One
// item is worked at a time: for each digit the divider takes the 32-bit
// dividend one byte a step (8 quotient bits a cycle), and the digit stack
// pops each digit through a read state and an output-load state. An item
// has 1 to 31 digits. The last digit may wait in the output register while
// the next item is already being divided.
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // value[30:0], radix[36:31], zero pad
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // digit_char[6:0], zero pad
  output logic                        out_tlast
);

  rdc_cmd_t cmd;
  rdc_sts_t sts;

  // sequencer
  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // divider, digit stack and output register
  rdc_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### src/rdc_ctrl.sv
`default_nettype none

module rdc_ctrl
  import rdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire rdc_sts_t sts,
  output rdc_cmd_t      cmd
);

  rdc_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done && sts.quo_zero) state_nxt = ST_POP_REQ;
      end
      ST_POP_REQ: begin
        if (sts.out_free) state_nxt = ST_POP_LOAD;
      end
      ST_POP_LOAD: begin
        state_nxt = sts.level_zero ? ST_IDLE : ST_POP_REQ;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DIV:      cmd.div_step = 1'b1;
      ST_POP_REQ:  cmd.pop_req  = sts.out_free;
      ST_POP_LOAD: cmd.pop_load = 1'b1;
      default: begin
        in_tready = 1'b0;
        cmd       = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/rdc_dpath.sv
`default_nettype none

module rdc_dpath
  import rdc_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire rdc_cmd_t               cmd,
  output rdc_sts_t                    sts,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  localparam int LVL_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  logic [DIV_W-1:0]   div_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [RADIX_W-1:0] radix_r;
  logic [STEP_W-1:0]  step_r;
  logic [LVL_W-1:0]   level_r;
  logic [DIGIT_W-1:0] rd_data_r;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;
  logic               out_valid_r;

  logic [DIGIT_W-1:0] digit_stack [MAX_DIGITS];

  logic [VALUE_W-1:0] in_value;
  logic [RADIX_W-1:0] in_radix;
  logic [RADIX_W-1:0] radix_sat;
  logic [DIV_W-1:0]   div_nxt;
  logic [DIGIT_W-1:0] rem_nxt;
  logic [DIV_BITS-1:0] qbits;
  logic               push;
  logic [LVL_W-1:0]   level_dec;

  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_radix = in_tdata[VALUE_W+RADIX_W-1:VALUE_W];

  // clamp radix into the supported range
  always_comb begin
    radix_sat = in_radix;
    if (in_radix < RADIX_MIN) radix_sat = RADIX_MIN;
    if (in_radix > RADIX_MAX) radix_sat = RADIX_MAX;
  end

  // restoring division over the top byte of the dividend
  always_comb begin
    logic [DIGIT_W-1:0] part;
    logic [DIGIT_W:0]   trial;
    part  = rem_r;
    qbits = '0;
    trial = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      trial = {part, div_r[DIV_W-DIV_BITS+i]};
      if (trial >= {1'b0, radix_r}) begin
        trial    = trial - {1'b0, radix_r};
        qbits[i] = 1'b1;
      end
      part = trial[DIGIT_W-1:0];
    end
    rem_nxt = part;
    div_nxt = {div_r[DIV_W-DIV_BITS-1:0], qbits};
  end

  assign sts.div_done   = (step_r == STEP_W'(DIV_STEPS - 1));
  assign sts.quo_zero   = (div_nxt == '0);
  assign sts.level_zero = (level_r == '0);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign push      = cmd.div_step && sts.div_done && (level_r < LVL_W'(MAX_DIGITS));
  assign level_dec = level_r - 1'b1;

  // dividend, remainder and radix
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_r   <= {{(DIV_W-VALUE_W){1'b0}}, in_value};
      rem_r   <= '0;
      radix_r <= radix_sat;
    end else if (cmd.div_step) begin
      div_r <= div_nxt;
      rem_r <= sts.div_done ? '0 : rem_nxt;
    end
  end

  // step counter and stack level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      level_r <= '0;
    end else begin
      if (cmd.load) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + 1'b1;
      end
      if (cmd.load) begin
        level_r <= '0;
      end else if (push) begin
        level_r <= level_r + 1'b1;
      end else if (cmd.pop_req) begin
        level_r <= level_dec;
      end
    end
  end

  // digit stack write port
  always_ff @(posedge clk) begin
    if (push) begin
      digit_stack[level_r[IDX_W-1:0]] <= rem_nxt;
    end
  end

  // digit stack read port
  always_ff @(posedge clk) begin
    if (cmd.pop_req) begin
      rd_data_r <= digit_stack[level_dec[IDX_W-1:0]];
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.pop_load) begin
      char_r <= digit_to_char(rd_data_r);
      last_r <= (level_r == '0);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pop_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CHAR_W){1'b0}}, char_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

### src/rdc_checker.sv
`default_nettype none

`include "radix_digit_converter_assert.svh"

module rdc_checker
  import rdc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  // every character is a digit or an upper-case letter
  `RDC_ASSERT_SAME(a_char_range, out_tvalid, (out_tdata[7] == 1'b0) && ((out_tdata[6:0] >= CHAR_ZERO && out_tdata[6:0] <= CHAR_NINE) || (out_tdata[6:0] >= CHAR_A && out_tdata[6:0] <= CHAR_Z)), "digit character out of range")

  // busy right after taking an item
  `RDC_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input accepted twice in a row")

  // a stalled result holds
  `RDC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // no new digit directly after the final one
  `RDC_ASSERT_NEXT(a_gap_after_last, out_tvalid && out_tready && out_tlast, !out_tvalid, "digit right after final digit")

  // no new item while a run of digits is still open
  `RDC_ASSERT_SAME(a_no_accept_mid_run, out_tvalid && !out_tlast, !in_tready, "ready during digit run")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
